FILE: design/cld_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cld_pkg: shared types and constants of the content-length deframer
// Result codes, error codes, the header key text and the shared structs.
// ----------------------------------------------------------------------------
package cld_pkg;

	localparam int HEADER_MAX = 8192;
	localparam int HDR_CNT_W  = $clog2(HEADER_MAX);

	localparam int LEN_W      = 31;
	localparam int ACC_W      = LEN_W + 1;
	localparam logic [ACC_W-1:0] LEN_CAP = ACC_W'({LEN_W{1'b1}});

	localparam int PREFIX_LEN = 15;
	localparam logic [4:0] PREFIX_END  = 5'(PREFIX_LEN);
	localparam logic [4:0] PREFIX_FAIL = 5'd31;

	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	typedef enum logic [1:0] {
		KIND_BODY  = 2'd0,
		KIND_EMPTY = 2'd1,
		KIND_ERROR = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ERR_NONE     = 2'd0,
		ERR_HDR_LONG = 2'd1,
		ERR_LEN_BAD  = 2'd2,
		ERR_LEN_OVER = 2'd3
	} err_t;

	typedef enum logic [2:0] {
		VS_NONE   = 3'd0,
		VS_BLANK  = 3'd1,
		VS_SIGN   = 3'd2,
		VS_DIGITS = 3'd3,
		VS_DONE   = 3'd4,
		VS_BAD    = 3'd5
	} vstage_t;

	// one result word
	typedef struct packed {
		kind_t      kind;
		logic [7:0] body_byte;
		logic       last;
		err_t       error_code;
	} res_t;

	// header parser verdict for the current byte
	typedef struct packed {
		logic             emit;
		res_t             res;
		logic             start_body;
		logic [LEN_W-1:0] len;
	} hdr_res_t;

	// lower-case key text, one character per position
	function automatic logic [7:0] key_char(input logic [3:0] idx);
		logic [7:0] ch;
		unique case (idx)
			4'd0:    ch = "c";
			4'd1:    ch = "o";
			4'd2:    ch = "n";
			4'd3:    ch = "t";
			4'd4:    ch = "e";
			4'd5:    ch = "n";
			4'd6:    ch = "t";
			4'd7:    ch = "-";
			4'd8:    ch = "l";
			4'd9:    ch = "e";
			4'd10:   ch = "n";
			4'd11:   ch = "g";
			4'd12:   ch = "t";
			4'd13:   ch = "h";
			4'd14:   ch = ":";
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

endpackage
`default_nettype wire

FILE: design/cld_header.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cld_header: header phase parser
// Tracks CRLFCRLF, matches the length key, parses the value and decides.
// ----------------------------------------------------------------------------
module cld_header (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       step,
	input  wire logic [7:0]                 byte_in,
	input  wire logic [cld_pkg::LEN_W-1:0]  max_len,
	output cld_pkg::hdr_res_t               res
);

	logic [cld_pkg::HDR_CNT_W-1:0] cnt_q;
	logic [1:0]                    em_q;
	logic [4:0]                    pp_q;
	cld_pkg::vstage_t              vs_q;
	logic [cld_pkg::ACC_W-1:0]     acc_q;
	logic                          ovf_q;
	logic                          neg_q;

	logic [cld_pkg::HDR_CNT_W:0]   cnt_n;
	logic [1:0]                    em_n;
	logic [4:0]                    pp_n;
	cld_pkg::vstage_t              vs_n;
	logic [cld_pkg::ACC_W-1:0]     acc_n;
	logic                          ovf_n;
	logic                          neg_n;
	logic                          line_break;
	logic                          hdr_end;
	logic                          too_long;
	logic                          clear;
	logic [7:0]                    low;
	logic                          is_digit;
	logic                          in_value;
	logic [cld_pkg::ACC_W+3:0]     acc_x10;

	assign low      = (byte_in >= "A" && byte_in <= "Z") ? byte_in + 8'd32 : byte_in;
	assign is_digit = (byte_in >= cld_pkg::CH_ZERO) && (byte_in <= cld_pkg::CH_NINE);
	assign in_value = (vs_q == cld_pkg::VS_BLANK) || (vs_q == cld_pkg::VS_SIGN) ||
	                  (vs_q == cld_pkg::VS_DIGITS);
	assign acc_x10  = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} +
	                  (cld_pkg::ACC_W+4)'(byte_in - cld_pkg::CH_ZERO);

	// end-of-header matcher
	always_comb begin
		em_n       = 2'd0;
		line_break = 1'b0;
		hdr_end    = 1'b0;
		if (byte_in == cld_pkg::CH_CR) begin
			em_n = (em_q == 2'd2) ? 2'd3 : 2'd1;
		end else if (byte_in == cld_pkg::CH_LF) begin
			if (em_q == 2'd1) begin
				em_n       = 2'd2;
				line_break = 1'b1;
			end else if (em_q == 2'd3) begin
				line_break = 1'b1;
				hdr_end    = 1'b1;
			end
		end
	end

	// value stage next state, key matcher and accumulator
	always_comb begin
		vs_n  = vs_q;
		pp_n  = pp_q;
		acc_n = acc_q;
		ovf_n = ovf_q;
		neg_n = neg_q;
		if (in_value) begin
			priority if (vs_q == cld_pkg::VS_BLANK &&
			             (byte_in == cld_pkg::CH_SP || byte_in == cld_pkg::CH_TAB)) begin
				vs_n = vs_q;
			end else if (vs_q == cld_pkg::VS_BLANK &&
			             (byte_in == cld_pkg::CH_PLUS || byte_in == cld_pkg::CH_MINUS)) begin
				neg_n = (byte_in == cld_pkg::CH_MINUS);
				vs_n  = cld_pkg::VS_SIGN;
			end else if (is_digit) begin
				if (!ovf_q) begin
					if (acc_x10 > (cld_pkg::ACC_W+4)'(cld_pkg::LEN_CAP)) begin
						ovf_n = 1'b1;
						acc_n = cld_pkg::LEN_CAP + 1'b1;
					end else begin
						acc_n = acc_x10[cld_pkg::ACC_W-1:0];
					end
				end
				vs_n = cld_pkg::VS_DIGITS;
			end else begin
				vs_n = (vs_q == cld_pkg::VS_DIGITS) ? cld_pkg::VS_DONE : cld_pkg::VS_BAD;
			end
		end else if (pp_q < cld_pkg::PREFIX_END) begin
			if (low == cld_pkg::key_char(pp_q[3:0])) begin
				pp_n = pp_q + 5'd1;
				if (pp_n == cld_pkg::PREFIX_END && vs_q == cld_pkg::VS_NONE)
					vs_n = cld_pkg::VS_BLANK;
			end else begin
				pp_n = cld_pkg::PREFIX_FAIL;
			end
		end
		if (line_break)
			pp_n = 5'd0;
	end

	assign cnt_n    = {1'b0, cnt_q} + 1'b1;
	assign too_long = (cnt_n == (cld_pkg::HDR_CNT_W+1)'(cld_pkg::HEADER_MAX));
	assign clear    = too_long || hdr_end;

	// verdict; a header end never changes the value, so registered value is used
	always_comb begin
		res                = '0;
		res.res.kind       = cld_pkg::KIND_ERROR;
		res.res.error_code = cld_pkg::ERR_NONE;
		res.len            = acc_q[cld_pkg::LEN_W-1:0];
		priority if (too_long) begin
			res.emit           = 1'b1;
			res.res.error_code = cld_pkg::ERR_HDR_LONG;
		end else if (!hdr_end) begin
			res.emit = 1'b0;
		end else if (vs_n != cld_pkg::VS_DIGITS && vs_n != cld_pkg::VS_DONE) begin
			res.emit           = 1'b1;
			res.res.error_code = cld_pkg::ERR_LEN_BAD;
		end else if (neg_q && (acc_q != '0 || ovf_q)) begin
			res.emit           = 1'b1;
			res.res.error_code = cld_pkg::ERR_LEN_BAD;
		end else if (ovf_q || acc_q > {1'b0, max_len}) begin
			res.emit           = 1'b1;
			res.res.error_code = cld_pkg::ERR_LEN_OVER;
		end else if (acc_q == '0) begin
			res.emit     = 1'b1;
			res.res.kind = cld_pkg::KIND_EMPTY;
			res.res.last = 1'b1;
		end else begin
			res.start_body = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			em_q  <= 2'd0;
			pp_q  <= 5'd0;
			vs_q  <= cld_pkg::VS_NONE;
			acc_q <= '0;
			ovf_q <= 1'b0;
			neg_q <= 1'b0;
		end else if (step) begin
			if (clear) begin
				cnt_q <= '0;
				em_q  <= 2'd0;
				pp_q  <= 5'd0;
				vs_q  <= cld_pkg::VS_NONE;
				acc_q <= '0;
				ovf_q <= 1'b0;
				neg_q <= 1'b0;
			end else begin
				cnt_q <= cnt_n[cld_pkg::HDR_CNT_W-1:0];
				em_q  <= em_n;
				pp_q  <= pp_n;
				vs_q  <= vs_n;
				acc_q <= acc_n;
				ovf_q <= ovf_n;
				neg_q <= neg_n;
			end
		end
	end

endmodule
`default_nettype wire

FILE: design/cld_body.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cld_body: body phase counter
// Counts body bytes down and flags the last one.
// ----------------------------------------------------------------------------
module cld_body (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      step,
	input  wire logic                      start,
	input  wire logic [cld_pkg::LEN_W-1:0] len,
	input  wire logic [7:0]                byte_in,
	output logic                           active,
	output cld_pkg::res_t                  res
);

	logic                      active_q;
	logic [cld_pkg::LEN_W-1:0] rem_q;
	logic [cld_pkg::LEN_W-1:0] rem_n;

	assign rem_n  = (rem_q != '0) ? rem_q - 1'b1 : rem_q;
	assign active = active_q;

	always_comb begin
		res            = '0;
		res.kind       = cld_pkg::KIND_BODY;
		res.body_byte  = byte_in;
		res.last       = (rem_n == '0);
		res.error_code = cld_pkg::ERR_NONE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			rem_q    <= '0;
		end else if (step) begin
			if (active_q) begin
				rem_q <= rem_n;
				if (rem_n == '0)
					active_q <= 1'b0;
			end else if (start) begin
				rem_q    <= len;
				active_q <= 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

FILE: design/cld_out_reg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cld_out_reg: result register
// Holds one result word until the receiver takes it.
// ----------------------------------------------------------------------------
module cld_out_reg (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          load,
	input  wire cld_pkg::res_t res_in,
	input  wire logic          out_ready,
	output logic               out_valid,
	output cld_pkg::res_t      res_out,
	output logic               free
);

	logic          valid_q;
	cld_pkg::res_t res_q;

	assign free      = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign res_out   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			res_q <= res_in;
	end

endmodule
`default_nettype wire

FILE: design/content_length_message_deframer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// content_length_message_deframer: Content-Length framed byte stream deframer
// Strips headers from a byte stream and passes message bodies through.
// ----------------------------------------------------------------------------
// Usage
//  - in channel: one stream byte per word (in_valid/in_ready/in_byte).
//  - out channel: one result word (kind, body_byte, last, error_code); header
//    bytes give no word except at header end (empty message or error) or on
//    an oversize header. Body bytes come out one word each, last on the final.
//  - cfg channel: max_body_length, always ready; write only while idle. It is
//    sampled when a header ends.
//  - Path: a byte waits in the input register and its result word is loaded
//    into the result register as the byte moves on; the word shows on the
//    out channel from that register until it is taken.
//  - Throughput: one byte per cycle; a byte moves on whenever the result
//    register is empty or being emptied in that cycle.
//  - Stall: with out_ready low and a word waiting, the byte in the input
//    register holds and in_ready drops once that register is full.
//  - Reset (arst_n low): header phase, all counters clear, nothing valid,
//    max_body_length back to its largest value.
// ----------------------------------------------------------------------------
module content_length_message_deframer (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	// byte stream
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic [7:0]                in_byte,
	// results
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic [1:0]                     kind,
	output logic [7:0]                     body_byte,
	output logic                           last,
	output logic [1:0]                     error_code,
	// configuration
	input  wire logic                      cfg_valid,
	output logic                           cfg_ready,
	input  wire logic [cld_pkg::LEN_W-1:0] max_body_length
);

	logic                      valid_s1;
	logic [7:0]                byte_s1;
	logic [cld_pkg::LEN_W-1:0] max_len_q;

	logic                      out_free;
	logic                      adv;
	logic                      body_active;
	cld_pkg::hdr_res_t         hdr_res;
	cld_pkg::res_t             body_res;
	cld_pkg::res_t             res_mux;
	cld_pkg::res_t             res_out;
	logic                      emit;

	// the stage-1 byte moves on only when the result register can take a word
	assign adv       = valid_s1 && out_free;
	assign in_ready  = !valid_s1 || adv;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			byte_s1 <= in_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= {cld_pkg::LEN_W{1'b1}};
		end else if (cfg_valid && cfg_ready) begin
			max_len_q <= max_body_length;
		end
	end

	// header parser only steps outside the body
	cld_header u_header (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (adv && !body_active),
		.byte_in (byte_s1),
		.max_len (max_len_q),
		.res     (hdr_res)
	);

	cld_body u_body (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (adv),
		.start   (hdr_res.start_body),
		.len     (hdr_res.len),
		.byte_in (byte_s1),
		.active  (body_active),
		.res     (body_res)
	);

	assign res_mux = body_active ? body_res : hdr_res.res;
	assign emit    = body_active || hdr_res.emit;

	cld_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (adv && emit),
		.res_in    (res_mux),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.res_out   (res_out),
		.free      (out_free)
	);

	assign kind       = res_out.kind;
	assign body_byte  = res_out.body_byte;
	assign last       = res_out.last;
	assign error_code = res_out.error_code;

endmodule
`default_nettype wire

FILE: design/cld_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cld_checker: port-level checks of the deframer
// Watches the result channel for word consistency and stall behaviour.
// ----------------------------------------------------------------------------
module cld_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [1:0] kind,
	input wire logic [7:0] body_byte,
	input wire logic       last,
	input wire logic [1:0] error_code
);

	// a stalled word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(body_byte) &&
		$stable(last) && $stable(error_code))
		else $error("result word changed while stalled");

	a_err_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == cld_pkg::KIND_ERROR |->
		error_code != cld_pkg::ERR_NONE && !last && body_byte == 8'h00)
		else $error("malformed error word");

	a_body_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == cld_pkg::KIND_BODY |-> error_code == cld_pkg::ERR_NONE)
		else $error("body word carries an error code");

	a_empty_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == cld_pkg::KIND_EMPTY |->
		last && error_code == cld_pkg::ERR_NONE && body_byte == 8'h00)
		else $error("malformed empty-message word");

	a_kind_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> kind == cld_pkg::KIND_BODY || kind == cld_pkg::KIND_EMPTY ||
		kind == cld_pkg::KIND_ERROR)
		else $error("reserved result kind");

endmodule

bind content_length_message_deframer cld_checker u_cld_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.kind       (kind),
	.body_byte  (body_byte),
	.last       (last),
	.error_code (error_code)
);
`default_nettype wire
